>>> src/fpa_pkg.sv
// Shared constants and operation codes for the fixed-point ALU.
package fpa_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int WORD_BITS_DEF = 32;

  localparam int OP_W        = 4;
  localparam int DATA_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - DATA_W - 1 - STATUS_W;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_DIV   = 4'd3,
    OP_LT    = 4'd4,
    OP_GT    = 4'd5,
    OP_LE    = 4'd6,
    OP_GE    = 4'd7,
    OP_EQ    = 4'd8,
    OP_NE    = 4'd9,
    OP_MIN   = 4'd10,
    OP_MAX   = 4'd11,
    OP_INC   = 4'd12,
    OP_DEC   = 4'd13,
    OP_TOINT = 4'd14
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2
  } status_t;

endpackage

>>> src/fpa_front.sv
// Operand decode, front-stage operations and magnitudes for the divide and multiply paths.
module fpa_front
  import fpa_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic [OP_W-1:0]      in_op,
  input  logic [DATA_W-1:0]    in_a,
  input  logic [DATA_W-1:0]    in_b,
  output logic                 valid_r,
  output logic [OP_W-1:0]      op_r,
  output logic [WORD_BITS-1:0] res_r,
  output logic                 cmp_r,
  output status_t              st_r,
  output logic [WORD_BITS-1:0] ma_r,
  output logic [WORD_BITS-1:0] mb_r,
  output logic                 neg_r,
  output logic                 a_neg_r
);

  localparam logic [WORD_BITS-1:0] MAXPOS = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] SBIT   = {1'b1, {(WORD_BITS-1){1'b0}}};

  logic [63:0]          a64, b64;
  logic [WORD_BITS-1:0] a_w, b_w, sum, diff;
  logic                 lt, gt, eq;
  logic [WORD_BITS-1:0] res_nxt;
  logic                 cmp_nxt;
  status_t              st_nxt;

  // operands: sign-extend the 32-bit field, then keep the word width
  assign a64  = {{32{in_a[DATA_W-1]}}, in_a};
  assign b64  = {{32{in_b[DATA_W-1]}}, in_b};
  assign a_w  = a64[WORD_BITS-1:0];
  assign b_w  = b64[WORD_BITS-1:0];
  assign sum  = a_w + b_w;
  assign diff = a_w - b_w;
  assign lt   = $signed(a_w) < $signed(b_w);
  assign gt   = $signed(b_w) < $signed(a_w);
  assign eq   = (a_w == b_w);

  always_comb begin
    res_nxt = '0;
    cmp_nxt = 1'b0;
    st_nxt  = ST_OK;
    unique case (in_op)
      OP_ADD: begin
        res_nxt = sum;
        if (!(a_w[WORD_BITS-1] ^ b_w[WORD_BITS-1]) && (sum[WORD_BITS-1] ^ a_w[WORD_BITS-1])) begin
          res_nxt = a_w[WORD_BITS-1] ? SBIT : MAXPOS;
          st_nxt  = ST_SAT;
        end
      end
      OP_SUB: begin
        res_nxt = diff;
        if ((a_w[WORD_BITS-1] ^ b_w[WORD_BITS-1]) && (diff[WORD_BITS-1] ^ a_w[WORD_BITS-1])) begin
          res_nxt = a_w[WORD_BITS-1] ? SBIT : MAXPOS;
          st_nxt  = ST_SAT;
        end
      end
      OP_LT:  cmp_nxt = lt;
      OP_GT:  cmp_nxt = gt;
      OP_LE:  cmp_nxt = !gt;
      OP_GE:  cmp_nxt = !lt;
      OP_EQ:  cmp_nxt = eq;
      OP_NE:  cmp_nxt = !eq;
      OP_MIN: res_nxt = gt ? b_w : a_w;
      OP_MAX: res_nxt = gt ? a_w : b_w;
      OP_INC: begin
        if (a_w == MAXPOS) begin
          res_nxt = MAXPOS;
          st_nxt  = ST_SAT;
        end else begin
          res_nxt = a_w + WORD_BITS'(1);
        end
      end
      OP_DEC: begin
        if (a_w == SBIT) begin
          res_nxt = SBIT;
          st_nxt  = ST_SAT;
        end else begin
          res_nxt = a_w - WORD_BITS'(1);
        end
      end
      OP_TOINT: res_nxt = WORD_BITS'($signed(a_w) >>> FRAC_BITS);
      default: ;  // mul and div finish downstream; unused code gives zeros
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
    if (adv) begin
      op_r    <= in_op;
      res_r   <= res_nxt;
      cmp_r   <= cmp_nxt;
      st_r    <= st_nxt;
      ma_r    <= a_w[WORD_BITS-1] ? (WORD_BITS'(0) - a_w) : a_w;
      mb_r    <= b_w[WORD_BITS-1] ? (WORD_BITS'(0) - b_w) : b_w;
      neg_r   <= a_w[WORD_BITS-1] ^ b_w[WORD_BITS-1];
      a_neg_r <= a_w[WORD_BITS-1];
    end
  end

endmodule

>>> src/fpa_mul.sv
// Pipelined multiply of magnitudes from half-width partial products, rounding, saturation and alignment delay.
module fpa_mul
  import fpa_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int DEPTH     = WORD_BITS_DEF + FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 adv,
  input  logic [WORD_BITS-1:0] ma,
  input  logic [WORD_BITS-1:0] mb,
  input  logic                 neg,
  output logic [WORD_BITS-1:0] res,
  output logic                 sat
);

  localparam int H  = (WORD_BITS + 1) / 2;
  localparam int PW = 4 * H;
  localparam logic [PW:0] HALF =
    (FRAC_BITS == 0) ? '0 : ((PW+1)'(1) << ((FRAC_BITS == 0) ? 0 : FRAC_BITS - 1));
  localparam logic [WORD_BITS-1:0] MAXPOS = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] SBIT   = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [PW:0] LIM_POS = (PW+1)'(MAXPOS);
  localparam logic [PW:0] LIM_NEG = (PW+1)'(SBIT);

  logic [H-1:0]   al, ah, bl, bh;
  logic [2*H-1:0] pll_r, plh_r, phl_r, phh_r;
  logic           neg1_r, neg2_r;
  logic [PW-1:0]  prod_r;
  logic [PW:0]    rounded;
  logic           sat_nxt;
  logic [WORD_BITS-1:0] res_nxt;
  logic [WORD_BITS-1:0] res_r [3:DEPTH];
  logic                 sat_r [3:DEPTH];

  assign al = ma[H-1:0];
  assign ah = H'(ma >> H);
  assign bl = mb[H-1:0];
  assign bh = H'(mb >> H);

  always_ff @(posedge clk) begin
    if (adv) begin
      pll_r  <= al * bl;
      plh_r  <= al * bh;
      phl_r  <= ah * bl;
      phh_r  <= ah * bh;
      neg1_r <= neg;
      prod_r <= {phh_r, pll_r} + (PW'(plh_r) << H) + (PW'(phl_r) << H);
      neg2_r <= neg1_r;
    end
  end

  // round half away from zero on the magnitude, then saturate
  assign rounded = ({1'b0, prod_r} + HALF) >> FRAC_BITS;
  assign sat_nxt = rounded > (neg2_r ? LIM_NEG : LIM_POS);

  always_comb begin
    if (sat_nxt) begin
      res_nxt = neg2_r ? SBIT : MAXPOS;
    end else if (neg2_r) begin
      res_nxt = WORD_BITS'(0) - rounded[WORD_BITS-1:0];
    end else begin
      res_nxt = rounded[WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r[3] <= res_nxt;
      sat_r[3] <= sat_nxt;
    end
  end

  for (genvar k = 4; k <= DEPTH; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (adv) begin
        res_r[k] <= res_r[k-1];
        sat_r[k] <= sat_r[k-1];
      end
    end
  end

  assign res = res_r[DEPTH];
  assign sat = sat_r[DEPTH];

endmodule

>>> src/fpa_div.sv
// Restoring divider, one quotient bit per pipeline stage, carrying the item's side data.
module fpa_div
  import fpa_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  logic                                 in_valid,
  input  logic [OP_W-1:0]                      in_op,
  input  logic [WORD_BITS-1:0]                 in_res,
  input  logic                                 in_cmp,
  input  status_t                              in_st,
  input  logic [WORD_BITS-1:0]                 in_ma,
  input  logic [WORD_BITS-1:0]                 in_mb,
  input  logic                                 in_neg,
  input  logic                                 in_a_neg,
  output logic                                 out_valid,
  output logic [OP_W-1:0]                      out_op,
  output logic [WORD_BITS-1:0]                 out_res,
  output logic                                 out_cmp,
  output status_t                              out_st,
  output logic [WORD_BITS+FRAC_BITS-1:0]       out_q,
  output logic [WORD_BITS-1:0]                 out_rem,
  output logic [WORD_BITS-1:0]                 out_mb,
  output logic                                 out_neg,
  output logic                                 out_a_neg
);

  localparam int NW = WORD_BITS + FRAC_BITS;

  logic                 v_r     [1:NW];
  logic [OP_W-1:0]      op_r    [1:NW];
  logic [WORD_BITS-1:0] res_r   [1:NW];
  logic                 cmp_r   [1:NW];
  status_t              st_r    [1:NW];
  logic [NW-1:0]        n_r     [1:NW];
  logic [NW-1:0]        q_r     [1:NW];
  logic [WORD_BITS-1:0] rem_r   [1:NW];
  logic [WORD_BITS-1:0] mb_r    [1:NW];
  logic                 neg_r   [1:NW];
  logic                 aneg_r  [1:NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic                 v_s, cmp_s, neg_s, aneg_s;
    logic [OP_W-1:0]      op_s;
    logic [WORD_BITS-1:0] res_s, rem_s, mb_s;
    status_t              st_s;
    logic [NW-1:0]        n_s, q_s;
    logic [WORD_BITS:0]   part, trial;
    logic                 ge;

    if (k == 0) begin : g_src
      assign v_s    = in_valid;
      assign op_s   = in_op;
      assign res_s  = in_res;
      assign cmp_s  = in_cmp;
      assign st_s   = in_st;
      assign n_s    = NW'(in_ma) << FRAC_BITS;
      assign q_s    = '0;
      assign rem_s  = '0;
      assign mb_s   = in_mb;
      assign neg_s  = in_neg;
      assign aneg_s = in_a_neg;
    end else begin : g_src
      assign v_s    = v_r[k];
      assign op_s   = op_r[k];
      assign res_s  = res_r[k];
      assign cmp_s  = cmp_r[k];
      assign st_s   = st_r[k];
      assign n_s    = n_r[k];
      assign q_s    = q_r[k];
      assign rem_s  = rem_r[k];
      assign mb_s   = mb_r[k];
      assign neg_s  = neg_r[k];
      assign aneg_s = aneg_r[k];
    end

    // shift in the next numerator bit, subtract the divisor when it fits
    assign part  = {rem_s, n_s[NW-1]};
    assign ge    = part >= {1'b0, mb_s};
    assign trial = part - {1'b0, mb_s};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (adv) begin
        v_r[k+1] <= v_s;
      end
      if (adv) begin
        op_r[k+1]   <= op_s;
        res_r[k+1]  <= res_s;
        cmp_r[k+1]  <= cmp_s;
        st_r[k+1]   <= st_s;
        n_r[k+1]    <= n_s << 1;
        q_r[k+1]    <= {q_s[NW-2:0], ge};
        rem_r[k+1]  <= ge ? trial[WORD_BITS-1:0] : part[WORD_BITS-1:0];
        mb_r[k+1]   <= mb_s;
        neg_r[k+1]  <= neg_s;
        aneg_r[k+1] <= aneg_s;
      end
    end
  end

  assign out_valid = v_r[NW];
  assign out_op    = op_r[NW];
  assign out_res   = res_r[NW];
  assign out_cmp   = cmp_r[NW];
  assign out_st    = st_r[NW];
  assign out_q     = q_r[NW];
  assign out_rem   = rem_r[NW];
  assign out_mb    = mb_r[NW];
  assign out_neg   = neg_r[NW];
  assign out_a_neg = aneg_r[NW];

endmodule

>>> src/fixed_point_alu.sv
// Top level of the pipelined fixed-point ALU: stream ports, result select and output register.
//
// Usage:
//   Input channel (in_*): one request per accepted beat. in_tuser carries the
//   operation code, in_tdata the two raw signed operands. Output channel
//   (out_*): one result per request, in request order, with the raw result,
//   the compare flag and a status (ok, saturated, divide by zero).
//   Path: an accepted request passes the front register, the divider
//   pipeline and the output register, whatever the operation (Q24.8 in a
//   32-bit word by default). The divider's one-quotient-bit-per-stage
//   pipeline sets that depth; the multiply path runs alongside it and is
//   delayed to match. Throughput: one request per cycle while not stalled.
//   Stall: the whole pipeline advances only while the output register is
//   empty or being drained; in_tready is low when out_tvalid is held against
//   a low out_tready, so nothing is dropped or duplicated.
//   Reset (rst_n low, synchronous): all valid bits clear, the pipeline is
//   empty and in_tready comes up high on the first cycle after reset.
//   Operands are taken as the low WORD_BITS bits of the sign-extended 32-bit
//   fields; results are the low 32 bits of the word-width result.
module fixed_point_alu
  import fpa_pkg::*;
#(
  parameter int FRACTION_BITS = FRAC_BITS_DEF,
  parameter int WORD_BITS     = WORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] a_raw, [63:32] b_raw
  input  logic [OP_W-1:0]        in_tuser,   // [3:0] operation
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [31:0] result_value, [32] compare_true,
                                             // [34:33] status, [39:35] zero
);

  localparam int NW = WORD_BITS + FRACTION_BITS;
  localparam logic [WORD_BITS-1:0] MAXPOS = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] SBIT   = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [NW:0] LIM_POS = (NW+1)'(MAXPOS);
  localparam logic [NW:0] LIM_NEG = (NW+1)'(SBIT);

  // global advance: every stage moves together when the output can take a beat
  logic adv;

  // front stage
  logic                 f_valid, f_cmp, f_neg, f_a_neg;
  logic [OP_W-1:0]      f_op;
  logic [WORD_BITS-1:0] f_res, f_ma, f_mb;
  status_t              f_st;

  // end of the divider pipeline
  logic                 d_valid, d_cmp, d_neg, d_a_neg;
  logic [OP_W-1:0]      d_op;
  logic [WORD_BITS-1:0] d_res, d_rem, d_mb;
  status_t              d_st;
  logic [NW-1:0]        d_q;

  // multiply path, aligned with the divider output
  logic [WORD_BITS-1:0] m_res;
  logic                 m_sat;

  // finish
  logic                 round_up, q_sat;
  logic [NW:0]          q_rnd;
  logic [WORD_BITS-1:0] res_fin;
  logic                 cmp_fin;
  status_t              st_fin;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  fpa_front #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRACTION_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_tvalid),
    .in_op    (in_tuser),
    .in_a     (in_tdata[DATA_W-1:0]),
    .in_b     (in_tdata[IN_TDATA_W-1:DATA_W]),
    .valid_r  (f_valid),
    .op_r     (f_op),
    .res_r    (f_res),
    .cmp_r    (f_cmp),
    .st_r     (f_st),
    .ma_r     (f_ma),
    .mb_r     (f_mb),
    .neg_r    (f_neg),
    .a_neg_r  (f_a_neg)
  );

  fpa_div #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRACTION_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (f_valid),
    .in_op     (f_op),
    .in_res    (f_res),
    .in_cmp    (f_cmp),
    .in_st     (f_st),
    .in_ma     (f_ma),
    .in_mb     (f_mb),
    .in_neg    (f_neg),
    .in_a_neg  (f_a_neg),
    .out_valid (d_valid),
    .out_op    (d_op),
    .out_res   (d_res),
    .out_cmp   (d_cmp),
    .out_st    (d_st),
    .out_q     (d_q),
    .out_rem   (d_rem),
    .out_mb    (d_mb),
    .out_neg   (d_neg),
    .out_a_neg (d_a_neg)
  );

  fpa_mul #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRACTION_BITS),
    .DEPTH     (NW)
  ) u_mul (
    .clk (clk),
    .adv (adv),
    .ma  (f_ma),
    .mb  (f_mb),
    .neg (f_neg),
    .res (m_res),
    .sat (m_sat)
  );

  // divide rounding: half away from zero when twice the remainder reaches the divisor
  assign round_up = {d_rem, 1'b0} >= {1'b0, d_mb};
  assign q_rnd    = {1'b0, d_q} + (NW+1)'(round_up);
  assign q_sat    = q_rnd > (d_neg ? LIM_NEG : LIM_POS);

  always_comb begin
    res_fin = d_res;
    cmp_fin = d_cmp;
    st_fin  = d_st;
    if (d_op == OP_MUL) begin
      res_fin = m_res;
      st_fin  = m_sat ? ST_SAT : ST_OK;
    end else if (d_op == OP_DIV) begin
      if (d_mb == '0) begin
        // divide by zero saturates toward the dividend's sign
        res_fin = d_a_neg ? SBIT : MAXPOS;
        st_fin  = ST_DIVZ;
      end else if (q_sat) begin
        res_fin = d_neg ? SBIT : MAXPOS;
        st_fin  = ST_SAT;
      end else begin
        res_fin = d_neg ? (WORD_BITS'(0) - q_rnd[WORD_BITS-1:0]) : q_rnd[WORD_BITS-1:0];
        st_fin  = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= d_valid;
    end
    if (adv) begin
      out_data_r <= {OUT_PAD_W'(0), st_fin, cmp_fin, DATA_W'(res_fin)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // status code 3 is never produced
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[DATA_W+2:DATA_W+1] != 2'd3))
    else $error("illegal status code on output");

  // a true compare carries a zero result and ok status
  a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[DATA_W]) |->
      (out_tdata[DATA_W-1:0] == '0) && (out_tdata[DATA_W+2:DATA_W+1] == ST_OK))
    else $error("compare result with nonzero value or status");

  // a held result blocks new requests
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("request taken while output stalled");

  // pipeline drains only on a taken result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("output result lost while stalled");

endmodule

>>> sim/fixed_point_alu_tb.sv
// Self-checking testbench for the fixed-point ALU stream block.
`timescale 1ns / 1ps

module fixed_point_alu_tb;
  import fpa_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int LATENCY = WORD_BITS_DEF + FRAC_BITS_DEF + 2;
  localparam logic [31:0] MAXP = 32'h7fff_ffff;
  localparam logic [31:0] MINN = 32'h8000_0000;
  localparam int N_RANDOM = 1400;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] value;
    logic        cmp;
    logic [1:0]  st;
  } alu_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [OP_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  alu_req_t pending_reqs[$];
  alu_res_t expected_results[$];
  int errors = 0;
  bit stim_done = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_cycles = 0;
  int accepted = 0;

  fixed_point_alu uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Magnitude-sign saturation for a wide exact result.
  function automatic alu_res_t saturate_wide(bit neg, logic [127:0] mag);
    alu_res_t r;
    logic [127:0] lim;
    r = '0;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (mag > lim) begin
      r.value = neg ? MINN : MAXP;
      r.st = ST_SAT;
    end else begin
      r.value = neg ? (32'd0 - mag[31:0]) : mag[31:0];
    end
    return r;
  endfunction

  // Expected result of one ALU request.
  function automatic alu_res_t alu_predict(alu_req_t q);
    alu_res_t r;
    logic signed [31:0] sa, sb;
    logic signed [32:0] sum;
    logic [127:0] ma, mb, prod, num, quo, rem;
    bit neg;
    r = '0;
    sa = q.a;
    sb = q.b;
    ma = sa[31] ? 128'(-64'(sa)) : 128'(sa);
    mb = sb[31] ? 128'(-64'(sb)) : 128'(sb);
    neg = sa[31] ^ sb[31];
    case (q.op)
      OP_ADD, OP_SUB: begin
        sum = (q.op == OP_ADD) ? (33'(sa) + 33'(sb)) : (33'(sa) - 33'(sb));
        if (sum > 33'sh0_7fff_ffff) begin r.value = MAXP; r.st = ST_SAT; end
        else if (sum < -33'sh0_8000_0000) begin r.value = MINN; r.st = ST_SAT; end
        else r.value = sum[31:0];
      end
      OP_MUL: begin
        prod = ma * mb;
        // round half away from zero on the magnitude
        prod = (prod >> FB) + ((prod >> (FB - 1)) & 128'd1);
        r = saturate_wide(neg, prod);
      end
      OP_DIV: begin
        if (mb == 0) begin
          r.value = sa[31] ? MINN : MAXP;
          r.st = ST_DIVZ;
        end else begin
          num = ma << FB;
          quo = num / mb;
          rem = num % mb;
          if ((rem << 1) >= mb) quo = quo + 1;
          r = saturate_wide(neg, quo);
        end
      end
      OP_LT: r.cmp = sa < sb;
      OP_GT: r.cmp = sa > sb;
      OP_LE: r.cmp = sa <= sb;
      OP_GE: r.cmp = sa >= sb;
      OP_EQ: r.cmp = sa == sb;
      OP_NE: r.cmp = sa != sb;
      OP_MIN: r.value = (sa > sb) ? q.b : q.a;
      OP_MAX: r.value = (sa > sb) ? q.a : q.b;
      OP_INC: begin
        if (q.a == MAXP) begin r.value = MAXP; r.st = ST_SAT; end
        else r.value = q.a + 32'd1;
      end
      OP_DEC: begin
        if (q.a == MINN) begin r.value = MINN; r.st = ST_SAT; end
        else r.value = q.a - 32'd1;
      end
      OP_TOINT: r.value = sa >>> FB;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return MAXP - $urandom_range(0, 3);
      1: return MINN + $urandom_range(0, 3);
      2: return $urandom_range(0, 1) ? 32'($urandom_range(0, 1024))
                                     : -32'($urandom_range(0, 1024));
      3: return 32'(0);
      // mid-range values keep mul and div away from constant saturation
      4: return 32'($signed($urandom()) >>> $urandom_range(8, 24));
      default: return $urandom();
    endcase
  endfunction

  task automatic push_req(logic [3:0] op, logic [31:0] a, logic [31:0] b);
    alu_req_t q;
    q.op = op;
    q.a = a;
    q.b = b;
    pending_reqs.push_back(q);
  endtask

  initial begin
    // directed: extremes, every opcode, saturation, divide by zero, code 15
    push_req(OP_ADD, MAXP, 32'd1);
    push_req(OP_ADD, MINN, MINN);
    push_req(OP_SUB, MINN, 32'd1);
    push_req(OP_SUB, MAXP, MINN);
    push_req(OP_MUL, MAXP, MAXP);
    push_req(OP_MUL, MINN, MINN);
    push_req(OP_MUL, 32'h0000_0180, 32'hffff_ff80);
    push_req(OP_DIV, 32'h0000_0100, 32'd0);
    push_req(OP_DIV, MINN, 32'd0);
    push_req(OP_DIV, 32'd0, 32'd0);
    push_req(OP_DIV, MINN, 32'h0000_0001);
    push_req(OP_DIV, 32'h0000_0100, 32'h0000_0300);
    push_req(OP_LT, MINN, MAXP);
    push_req(OP_GT, MINN, MAXP);
    push_req(OP_LE, MAXP, MAXP);
    push_req(OP_GE, MINN, MAXP);
    push_req(OP_EQ, MAXP, MAXP);
    push_req(OP_NE, MINN, MAXP);
    push_req(OP_MIN, MINN, MAXP);
    push_req(OP_MAX, MINN, MAXP);
    push_req(OP_INC, MAXP, 32'hffff_ffff);
    push_req(OP_DEC, MINN, 32'hffff_ffff);
    push_req(OP_TOINT, MINN, 32'd0);
    push_req(OP_TOINT, 32'hffff_ff7f, 32'd0);
    push_req(4'd15, 32'hffff_ffff, 32'hffff_ffff);
    for (int i = 0; i < N_RANDOM; i++)
      push_req(($urandom_range(0, 31) == 0) ? 4'd15 : 4'($urandom_range(0, 14)),
               rand_operand(), rand_operand());
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Driver: pops one request at a time, random gap before each offer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(alu_predict({in_tuser, in_tdata[31:0], in_tdata[63:32]}));
        accepted <= accepted + 1;
        send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
      end
      if (in_tvalid && !in_tready) begin
        // keep offering the same request
      end else if (send_gap > 0 && !(in_tvalid && in_tready)) begin
        send_gap <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (!(in_tvalid && in_tready) || send_gap == 0) begin
        if (!(in_tvalid && in_tready && send_gap != 0) && pending_reqs.size() > 0
            && !(in_tvalid && in_tready && $urandom_range(0, 3) == 0)) begin
          alu_req_t q;
          q = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= q.op;
          in_tdata <= {q.b, q.a};
        end else begin
          in_tvalid <= 1'b0;
          if (pending_reqs.size() == 0) stim_done <= 1'b1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result; receiver stalls at random, once for a long stretch.
  always @(posedge clk) begin
    alu_res_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[31:0], out_tdata[32], out_tdata[34:33]};
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: %h", out_tdata);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.value !== want.value) begin
            $error("result_value: expected %h, got %h", want.value, got.value);
            errors++;
          end
          if (got.cmp !== want.cmp) begin
            $error("compare_true: expected %b, got %b", want.cmp, got.cmp);
            errors++;
          end
          if (got.st !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, got.st);
            errors++;
          end
        end
        recv_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
      end
      if (accepted == 300 && hold_cycles == 0) hold_cycles <= 200;
      if (hold_cycles > 1) begin
        hold_cycles <= hold_cycles - 1;
        out_tready <= 1'b0;
      end else if (hold_cycles == 1) begin
        hold_cycles <= 0;
        out_tready <= 1'b1;
      end else if (recv_gap > 0 && !(out_tvalid && out_tready)) begin
        recv_gap <= recv_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(out_tvalid && out_tready) || recv_gap == 0;
      end
    end
  end

  initial begin
    wait (stim_done && !in_tvalid);
    wait (expected_results.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
